// File: rtl/sntp_pkg.sv
// Shared types and constants for the SNTP offset estimator.
// Field widths, action codes, register indexes and per-stage payload structs.
// No dependencies.
package sntp_pkg;

   localparam int COUNTER_WIDTH = 32;   // round counters wrap at this width

   localparam int ACT_W      = 2;
   localparam int TIME_W     = 63;      // local epoch microseconds
   localparam int NTP_W      = 32;      // NTP seconds / fraction
   localparam int US_W       = 52;      // NTP time converted to microseconds
   localparam int FRAC_US_W  = 20;      // fraction term, < 1e6
   localparam int SAMPLE_W   = 64;
   localparam int CNT_OUT_W  = 32;
   localparam int THR_W      = 32;
   localparam int ATT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [FRAC_US_W-1:0] US_PER_S       = 20'd1000000;
   localparam logic [NTP_W-1:0]     NTP_GAP_S      = 32'd2208988800;
   localparam logic [US_W-1:0]      NTP_GAP_US     = 52'd2208988800000000;
   localparam logic [THR_W-1:0]     THRESHOLD_INIT = 32'd20000;
   localparam logic [ATT_W-1:0]     ATTEMPTS_INIT  = 4'd3;
   localparam logic [SAMPLE_W-1:0]  DELAY_MAX      = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0]  DELAY_MIN      = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_EN   = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_ANSWERED = 2'd0,
      ACT_FAILED   = 2'd1,
      ACT_QUERY    = 2'd2
   } action_type;

   // input register
   typedef struct packed {
      action_type        action;
      logic [TIME_W-1:0] t1;
      logic [TIME_W-1:0] t4;
      logic [TIME_W-1:0] local_us;
      logic [NTP_W-1:0]  rx_sec;
      logic [NTP_W-1:0]  rx_frac;
      logic [NTP_W-1:0]  tx_sec;
      logic [NTP_W-1:0]  tx_frac;
   } stage_a_type;

   // products of the timestamp conversion
   typedef struct packed {
      action_type           action;
      logic [TIME_W-1:0]    t1;
      logic [TIME_W-1:0]    t4;
      logic [TIME_W-1:0]    local_us;
      logic [US_W-1:0]      rx_sec_us;
      logic [US_W-1:0]      tx_sec_us;
      logic [FRAC_US_W-1:0] rx_frac_us;
      logic [FRAC_US_W-1:0] tx_frac_us;
      logic                 rx_unix;   // seconds past the 1970 boundary
      logic                 tx_unix;
   } stage_b_type;

   // converted server timestamps
   typedef struct packed {
      action_type        action;
      logic [TIME_W-1:0] t1;
      logic [TIME_W-1:0] t4;
      logic [TIME_W-1:0] local_us;
      logic [US_W-1:0]   t2;
      logic [US_W-1:0]   t3;
   } stage_c_type;

   // sample offset and delay
   typedef struct packed {
      action_type                  action;
      logic [TIME_W-1:0]           local_us;
      logic signed [SAMPLE_W-1:0]  s_off;
      logic signed [SAMPLE_W-1:0]  s_del;
   } stage_d_type;

endpackage

// File: rtl/sntp_offset_estimator.sv
// SNTP clock offset and round-trip delay estimator, top level.
// Depends on sntp_pkg (types, widths, constants).

// One item per clock cycle, sustained while rsp_ready stays high. An item
// passes through the input register, timestamp multiply, conversion,
// offset/delay, then the round-state update with the result register, and a
// low rsp_ready holds the result in the result register. Each stage has
// its own valid bit and stalls only when the stage after it is full and
// blocked, so req_ready stays high while a result waits as long as the
// pipeline has a free slot. All round state (best sample, attempt count,
// committed offset, counters) lives in the last stage and is updated there in
// item order, so back-to-back attempts and queries see each other's effect.
// csr writes take effect at once; issue them only with the pipeline empty.
// Action 3 changes nothing and returns zeros plus the current status.
module sntp_offset_estimator (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sntp_pkg::ACT_W-1:0]           req_action,
   input  logic [sntp_pkg::TIME_W-1:0]          req_send_local_us,
   input  logic [sntp_pkg::TIME_W-1:0]          req_recv_local_us,
   input  logic [sntp_pkg::NTP_W-1:0]           req_server_rx_seconds,
   input  logic [sntp_pkg::NTP_W-1:0]           req_server_rx_fraction,
   input  logic [sntp_pkg::NTP_W-1:0]           req_server_tx_seconds,
   input  logic [sntp_pkg::NTP_W-1:0]           req_server_tx_fraction,
   input  logic [sntp_pkg::TIME_W-1:0]          req_local_time_us,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sntp_pkg::SAMPLE_W-1:0] rsp_corrected_time_us,
   output logic signed [sntp_pkg::SAMPLE_W-1:0] rsp_sample_offset_us,
   output logic signed [sntp_pkg::SAMPLE_W-1:0] rsp_sample_delay_us,
   output logic signed [sntp_pkg::SAMPLE_W-1:0] rsp_committed_offset_us,
   output logic                                 rsp_round_closed,
   output logic                                 rsp_synced,
   output logic [sntp_pkg::CNT_OUT_W-1:0]       rsp_good_rounds,
   output logic [sntp_pkg::CNT_OUT_W-1:0]       rsp_failed_rounds,

   input  logic                                 csr_we,
   input  logic [sntp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sntp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sntp_pkg::*;

   // ---------------- configuration ----------------
   logic [THR_W-1:0] threshold_ff;
   logic [ATT_W-1:0] max_attempts_ff;
   logic             corr_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_INIT;
         max_attempts_ff <= ATTEMPTS_INIT;
         corr_en_ff      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff    <= csr_wdata[THR_W-1:0];
            CSR_ATTEMPTS:  max_attempts_ff <= csr_wdata[ATT_W-1:0];
            CSR_CORR_EN:   corr_en_ff      <= csr_wdata[0];
            default: ;     // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic a_ready, b_ready, c_ready, d_ready, r_ready;

   assign r_ready   = !rsp_valid_ff || rsp_ready;
   assign d_ready   = !d_valid_ff   || r_ready;
   assign c_ready   = !c_valid_ff   || d_ready;
   assign b_ready   = !b_valid_ff   || c_ready;
   assign a_ready   = !a_valid_ff   || b_ready;
   assign req_ready = a_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff   <= req_valid;
         if (b_ready) b_valid_ff   <= a_valid_ff;
         if (c_ready) c_valid_ff   <= b_valid_ff;
         if (d_ready) d_valid_ff   <= c_valid_ff;
         if (r_ready) rsp_valid_ff <= d_valid_ff;
      end
   end

   // ---------------- stage A: input register ----------------
   stage_a_type a_ff, a_in;

   always_comb begin
      a_in.action   = action_type'(req_action);
      a_in.t1       = req_send_local_us;
      a_in.t4       = req_recv_local_us;
      a_in.local_us = req_local_time_us;
      a_in.rx_sec   = req_server_rx_seconds;
      a_in.rx_frac  = req_server_rx_fraction;
      a_in.tx_sec   = req_server_tx_seconds;
      a_in.tx_frac  = req_server_tx_fraction;
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) a_ff <= a_in;
   end

   // ---------------- stage B: multiply by 1e6 ----------------
   stage_b_type     b_ff, b_in;
   logic [US_W-1:0] rx_frac_prod, tx_frac_prod;

   always_comb begin
      // fraction term is (frac * 1e6) >> 32
      rx_frac_prod    = US_W'(a_ff.rx_frac) * US_W'(US_PER_S);
      tx_frac_prod    = US_W'(a_ff.tx_frac) * US_W'(US_PER_S);
      b_in.action     = a_ff.action;
      b_in.t1         = a_ff.t1;
      b_in.t4         = a_ff.t4;
      b_in.local_us   = a_ff.local_us;
      b_in.rx_sec_us  = US_W'(a_ff.rx_sec) * US_W'(US_PER_S);
      b_in.tx_sec_us  = US_W'(a_ff.tx_sec) * US_W'(US_PER_S);
      b_in.rx_frac_us = rx_frac_prod[US_W-1:NTP_W];
      b_in.tx_frac_us = tx_frac_prod[US_W-1:NTP_W];
      b_in.rx_unix    = (a_ff.rx_sec >= NTP_GAP_S);
      b_in.tx_unix    = (a_ff.tx_sec >= NTP_GAP_S);
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) b_ff <= b_in;
   end

   // ---------------- stage C: epoch microseconds ----------------
   // era shift is applied after the multiply as a constant 1e6-scaled subtract
   stage_c_type c_ff, c_in;

   always_comb begin
      c_in.action   = b_ff.action;
      c_in.t1       = b_ff.t1;
      c_in.t4       = b_ff.t4;
      c_in.local_us = b_ff.local_us;
      c_in.t2 = b_ff.rx_sec_us - (b_ff.rx_unix ? NTP_GAP_US : '0)
              + US_W'(b_ff.rx_frac_us);
      c_in.t3 = b_ff.tx_sec_us - (b_ff.tx_unix ? NTP_GAP_US : '0)
              + US_W'(b_ff.tx_frac_us);
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) c_ff <= c_in;
   end

   // ---------------- stage D: offset and delay ----------------
   stage_d_type              d_ff, d_in;
   logic signed [SAMPLE_W:0] off_sum, off_adj, off_half, del_sum;

   always_comb begin
      // 65-bit exact sums; every term is non-negative and below 2^63
      off_sum = $signed((SAMPLE_W+1)'(c_ff.t2)) + $signed((SAMPLE_W+1)'(c_ff.t3))
              - $signed((SAMPLE_W+1)'(c_ff.t1)) - $signed((SAMPLE_W+1)'(c_ff.t4));
      del_sum = $signed((SAMPLE_W+1)'(c_ff.t4)) + $signed((SAMPLE_W+1)'(c_ff.t2))
              - $signed((SAMPLE_W+1)'(c_ff.t1)) - $signed((SAMPLE_W+1)'(c_ff.t3));
      // halve with truncation toward zero: bias negatives by one first
      off_adj  = off_sum + $signed({{SAMPLE_W{1'b0}}, off_sum[SAMPLE_W]});
      off_half = off_adj >>> 1;

      d_in.action   = c_ff.action;
      d_in.local_us = c_ff.local_us;
      d_in.s_off    = off_half[SAMPLE_W-1:0];
      // saturate delay into the signed 64-bit range
      if (!del_sum[SAMPLE_W] && del_sum[SAMPLE_W-1]) begin
         d_in.s_del = DELAY_MAX;
      end else if (del_sum[SAMPLE_W] && !del_sum[SAMPLE_W-1]) begin
         d_in.s_del = DELAY_MIN;
      end else begin
         d_in.s_del = del_sum[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && c_valid_ff) d_ff <= d_in;
   end

   // ---------------- last stage: round state and result ----------------
   logic                       d_fire;
   logic signed [SAMPLE_W-1:0] clock_offset_ff, clock_offset_in;
   logic                       synced_ff, synced_in;
   logic [COUNTER_WIDTH-1:0]   good_cnt_ff, good_cnt_in;
   logic [COUNTER_WIDTH-1:0]   failed_cnt_ff, failed_cnt_in;
   logic signed [SAMPLE_W-1:0] best_off_ff, best_off_in;
   logic signed [SAMPLE_W-1:0] best_del_ff, best_del_in;
   logic                       any_ff, any_in;
   logic [ATT_W-1:0]           attempt_ff, attempt_in;

   logic                       answered, attempted, better, early, close;
   logic                       any_next;
   logic [ATT_W-1:0]           limit, attempt_next;
   logic signed [SAMPLE_W-1:0] best_off_next, best_del_next;
   logic [SAMPLE_W-1:0]        corrected;

   assign d_fire = d_valid_ff && r_ready;

   always_comb begin
      answered  = 1'b0;
      attempted = 1'b0;
      corrected = '0;
      unique case (d_ff.action)
         ACT_ANSWERED: begin
            answered  = 1'b1;
            attempted = 1'b1;
         end
         ACT_FAILED: begin
            attempted = 1'b1;
         end
         ACT_QUERY: begin
            corrected = corr_en_ff ? SAMPLE_W'(d_ff.local_us) + clock_offset_ff
                                   : SAMPLE_W'(d_ff.local_us);
         end
         default: ;   // no-op action
      endcase

      // zero max_attempts behaves as one
      limit         = (max_attempts_ff == '0) ? ATT_W'(1) : max_attempts_ff;
      attempt_next  = attempt_ff + ATT_W'(1);
      better        = answered && (d_ff.s_del < best_del_ff);
      early         = answered && (d_ff.s_del < $signed(SAMPLE_W'(threshold_ff)));
      any_next      = any_ff || answered;
      best_off_next = better ? d_ff.s_off : best_off_ff;
      best_del_next = better ? d_ff.s_del : best_del_ff;
      close         = attempted && (early || (attempt_next >= limit));

      clock_offset_in = clock_offset_ff;
      synced_in       = synced_ff;
      good_cnt_in     = good_cnt_ff;
      failed_cnt_in   = failed_cnt_ff;
      best_off_in     = best_off_ff;
      best_del_in     = best_del_ff;
      any_in          = any_ff;
      attempt_in      = attempt_ff;

      if (d_fire && close) begin
         if (any_next) begin
            clock_offset_in = best_off_next;
            synced_in       = 1'b1;
            good_cnt_in     = good_cnt_ff + COUNTER_WIDTH'(1);
         end else begin
            failed_cnt_in   = failed_cnt_ff + COUNTER_WIDTH'(1);
         end
         // start a fresh round
         best_off_in = '0;
         best_del_in = DELAY_MAX;
         any_in      = 1'b0;
         attempt_in  = '0;
      end else if (d_fire && attempted) begin
         best_off_in = best_off_next;
         best_del_in = best_del_next;
         any_in      = any_next;
         attempt_in  = attempt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_offset_ff <= '0;
         synced_ff       <= 1'b0;
         good_cnt_ff     <= '0;
         failed_cnt_ff   <= '0;
         best_off_ff     <= '0;
         best_del_ff     <= DELAY_MAX;
         any_ff          <= 1'b0;
         attempt_ff      <= '0;
      end else begin
         clock_offset_ff <= clock_offset_in;
         synced_ff       <= synced_in;
         good_cnt_ff     <= good_cnt_in;
         failed_cnt_ff   <= failed_cnt_in;
         best_off_ff     <= best_off_in;
         best_del_ff     <= best_del_in;
         any_ff          <= any_in;
         attempt_ff      <= attempt_in;
      end
   end

   // result register: snapshot of the state right after this item
   logic signed [SAMPLE_W-1:0] rsp_corrected_ff, rsp_off_ff, rsp_del_ff, rsp_committed_ff;
   logic                       rsp_closed_ff, rsp_synced_ff;
   logic [CNT_OUT_W-1:0]       rsp_good_ff, rsp_failed_ff;

   always_ff @(posedge clock) begin
      if (d_fire) begin
         rsp_corrected_ff <= corrected;
         rsp_off_ff       <= answered ? d_ff.s_off : '0;
         rsp_del_ff       <= answered ? d_ff.s_del : '0;
         rsp_committed_ff <= clock_offset_in;
         rsp_closed_ff    <= close;
         rsp_synced_ff    <= synced_in;
         rsp_good_ff      <= CNT_OUT_W'(good_cnt_in);
         rsp_failed_ff    <= CNT_OUT_W'(failed_cnt_in);
      end
   end

   assign rsp_corrected_time_us   = rsp_corrected_ff;
   assign rsp_sample_offset_us    = rsp_off_ff;
   assign rsp_sample_delay_us     = rsp_del_ff;
   assign rsp_committed_offset_us = rsp_committed_ff;
   assign rsp_round_closed        = rsp_closed_ff;
   assign rsp_synced              = rsp_synced_ff;
   assign rsp_good_rounds         = rsp_good_ff;
   assign rsp_failed_rounds       = rsp_failed_ff;

endmodule
